>>> rtl/core/tpe_pkg.sv
// Types and constants shared by the TCP payload extractor.
// Word layouts for both channels and the fixed header positions.
// No dependencies.
package tpe_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } tpe_in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_printable;
    logic       payload_last;
  } tpe_out_t;

  localparam int ETH_HEADER_BYTES = 14;
  localparam int WORD_BYTES       = 2;

  // byte positions of captured header fields
  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_IHL      = ETH_HEADER_BYTES;
  localparam int POS_TLEN_HI  = ETH_HEADER_BYTES + WORD_BYTES;
  localparam int POS_TLEN_LO  = ETH_HEADER_BYTES + WORD_BYTES + 1;
  localparam int POS_PROTO    = ETH_HEADER_BYTES + 9;
  localparam int TCP_OFF_BYTE = 12;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PRINT_LOW      = 8'h20;
  localparam logic [7:0]  PRINT_HIGH     = 8'h7E;

endpackage

>>> rtl/core/tpe_header_track.sv
// Frame position counter, header field capture and payload window decision.
// Depends on tpe_pkg.
module tpe_header_track #(
  parameter int POSITION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tpe_pkg::tpe_in_t item,
  output logic             emit,
  output tpe_pkg::tpe_out_t result
);
  import tpe_pkg::*;

  // wide enough for the position and for 14 + a 16-bit total length
  localparam int CW = ((POSITION_BITS > 17) ? POSITION_BITS : 17) + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [POSITION_BITS-1:0] byte_position;
  logic [15:0]              ether_type_word;
  logic [3:0]               ip_header_words;
  logic [15:0]              ip_total_length;
  logic [7:0]               ip_protocol;
  logic [3:0]               tcp_offset_words;
  logic                     payload_done;

  logic [CW-1:0] pos_w;
  logic [CW-1:0] tcp_start;
  logic [CW-1:0] off_pos;
  logic [CW-1:0] pay_start;
  logic [CW-1:0] pay_end;
  logic          at_end;
  logic [7:0]    b;

  assign b         = item.frame_byte;
  assign pos_w     = CW'(byte_position);
  assign tcp_start = CW'(ETH_HEADER_BYTES) + CW'({ip_header_words, 2'b00});
  assign off_pos   = tcp_start + CW'(TCP_OFF_BYTE);
  assign pay_start = tcp_start + CW'({tcp_offset_words, 2'b00});
  assign pay_end   = CW'(ETH_HEADER_BYTES) + CW'(ip_total_length);
  assign at_end    = (pos_w + CW'(1)) == pay_end;

  // header bytes all sit before the first possible payload byte,
  // so the stored fields are already final whenever a byte can emit
  assign emit = (ether_type_word == ETHERTYPE_IPV4) && (ip_protocol == PROTO_TCP) &&
                !payload_done && (byte_position != POS_MAX) &&
                (pos_w > off_pos) && (pos_w >= pay_start) && (pos_w < pay_end);

  always_comb begin
    result.payload_byte = b;
    result.is_printable = (b >= PRINT_LOW) && (b <= PRINT_HIGH);
    result.payload_last = at_end || item.frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      ether_type_word  <= '0;
      ip_header_words  <= '0;
      ip_total_length  <= '0;
      ip_protocol      <= '0;
      tcp_offset_words <= '0;
      payload_done     <= 1'b0;
    end else if (step) begin
      if (item.frame_last) begin
        byte_position    <= '0;
        ether_type_word  <= '0;
        ip_header_words  <= '0;
        ip_total_length  <= '0;
        ip_protocol      <= '0;
        tcp_offset_words <= '0;
        payload_done     <= 1'b0;
      end else begin
        if (byte_position != POS_MAX) begin
          byte_position <= byte_position + 1'b1;
        end
        if (byte_position == POSITION_BITS'(POS_ETYPE_HI)) begin
          ether_type_word[15:8] <= b;
        end
        if (byte_position == POSITION_BITS'(POS_ETYPE_LO)) begin
          ether_type_word[7:0] <= b;
        end
        if (byte_position == POSITION_BITS'(POS_IHL)) begin
          ip_header_words <= b[3:0];
        end
        if (byte_position == POSITION_BITS'(POS_TLEN_HI)) begin
          ip_total_length[15:8] <= b;
        end
        if (byte_position == POSITION_BITS'(POS_TLEN_LO)) begin
          ip_total_length[7:0] <= b;
        end
        if (byte_position == POSITION_BITS'(POS_PROTO)) begin
          ip_protocol <= b;
        end
        if (pos_w == off_pos) begin
          tcp_offset_words <= b[7:4];
        end
        if (emit && at_end) begin
          payload_done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/tpe_out_stage.sv
// Result register for the payload channel; holds a word while stalled.
// Depends on tpe_pkg.
module tpe_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tpe_pkg::tpe_out_t load_word,
  output logic              out_valid,
  input  logic              out_stall,
  output tpe_pkg::tpe_out_t out_word
);
  import tpe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= load_word;
    end
  end

endmodule

>>> rtl/core/tcp_payload_extractor_unit.sv
// TCP payload extractor: takes Ethernet frame bytes one word per cycle while
// in_stall is low and passes on the TCP payload bytes of IPv4/TCP frames, each
// flagged printable or not, with payload_last on the final one. An accepted
// byte is registered, then judged against the captured header fields and, if
// it is payload, lands in the result register once that register is free to
// take it. One byte is accepted every cycle; in_stall rises only when the
// result register is full and stalled and the pending byte is itself payload.
// Depends on tpe_pkg, tpe_header_track and tpe_out_stage.
module tcp_payload_extractor_unit #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tpe_pkg::tpe_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output tpe_pkg::tpe_out_t out_word
);
  import tpe_pkg::*;

  logic     s1_valid;
  tpe_in_t  s1_word;
  logic     s1_adv;
  logic     emit;
  tpe_out_t result;

  assign s1_adv   = s1_valid && (!emit || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word <= in_word;
    end
  end

  tpe_header_track #(
    .POSITION_BITS(POSITION_BITS)
  ) u_track (
    .clk   (clk),
    .rst   (rst),
    .step  (s1_adv),
    .item  (s1_word),
    .emit  (emit),
    .result(result)
  );

  tpe_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_adv && emit),
    .load_word(result),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // input backs up only behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && emit && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_word)))
    else $error("pending byte lost while blocked");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !(s1_adv && emit)) |=> !out_valid)
    else $error("result word repeated after being taken");

endmodule
